>>> hdl/mrs_pkg.sv
// Shared types, constants and the CRC-16 step for the Modbus RTU slave engine.
`timescale 1ns / 1ps

package mrs_pkg;

  localparam int FRAME_BYTES_DEF = 64;
  localparam int REG_COUNT_DEF   = 256;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0]  FN_EXC_FLAG = 8'h80;

  localparam logic [7:0] FN_READ_COILS  = 8'h01;
  localparam logic [7:0] FN_READ_DISCRETE = 8'h02;
  localparam logic [7:0] FN_READ_HOLD   = 8'h03;
  localparam logic [7:0] FN_READ_INPUT  = 8'h04;
  localparam logic [7:0] FN_WRITE_COIL  = 8'h05;
  localparam logic [7:0] FN_WRITE_ONE   = 8'h06;
  localparam logic [7:0] FN_READ_STATUS = 8'h07;
  localparam logic [7:0] FN_WRITE_COILS = 8'h0F;
  localparam logic [7:0] FN_WRITE_MANY  = 8'h10;
  localparam logic [7:0] FN_LAST_FIXED  = 8'h06;

  localparam logic [7:0] EXC_NONE     = 8'h00;
  localparam logic [7:0] EXC_FUNCTION = 8'h01;
  localparam logic [7:0] EXC_ADDRESS  = 8'h02;
  localparam logic [7:0] EXC_VALUE    = 8'h03;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic REG_SLAVE_ADDR = 1'b0;
  localparam logic REG_TIMEOUT    = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } out_t;

  // Fold one byte into a reflected CRC-16.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/mrs_reg_store.sv
// Register store: single-port synchronous RAM with a zeroing sweep after reset.
`timescale 1ns / 1ps

module mrs_reg_store #(
  parameter int REG_COUNT = mrs_pkg::REG_COUNT_DEF,
  parameter int RW        = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [RW-1:0] addr_i,
  input  logic [15:0]   wdata_i,
  output logic [15:0]   rdata_o,
  output logic          busy_o
);

  localparam logic [RW-1:0] LAST_IDX = RW'(REG_COUNT - 1);

  logic [15:0]   mem [REG_COUNT];
  logic [15:0]   rdata_q;
  logic          clr_q, clr_d;
  logic [RW-1:0] cnt_q, cnt_d;

  always_comb begin
    clr_d = clr_q;
    cnt_d = cnt_q;
    if (clr_q) begin
      cnt_d = cnt_q + RW'(1);
      if (cnt_q == LAST_IDX) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      cnt_q <= '0;
    end else begin
      clr_q <= clr_d;
      cnt_q <= cnt_d;
    end
  end

  // Sweep zeros while clearing, else take the engine's write.
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[cnt_q] <= 16'h0000;
    end else if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_q;

endmodule

>>> hdl/modbus_rtu_slave_register_engine_top.sv
// Top level of the Modbus RTU slave register engine.
`timescale 1ns / 1ps
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+--------------------------
//  item     | start / busy                    | item_i  (op, rx_byte)
//  result   | res_valid_o, one-cycle strobe   | res_o   (tx_byte, last_byte)
//  config   | APB psel/penable/pwrite/pready  | paddr, pwdata, prdata
//
// A tick transfer is absorbed in its accept cycle. A byte transfer is stored
// on accept and then passes the frame decision (S_DECIDE). A completed frame
// walks the frame RAM byte by byte (S_CRD, S_CACC) for the CRC check, then
// serves: S_WHI, S_WLO, S_WWR per register written, S_HEAD per header byte,
// S_RRD, S_RHI, S_RLO per read register, S_KRD, S_KUSE per coil; all bound
// by the single RAM read port. After reset the store is zeroed with busy high.
// Results cannot be stalled: each reply byte is driven for exactly one cycle.

module modbus_rtu_slave_register_engine_top #(
  parameter int FRAME_BYTES = mrs_pkg::FRAME_BYTES_DEF,
  parameter int REG_COUNT   = mrs_pkg::REG_COUNT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  mrs_pkg::in_t item_i,
  output logic         res_valid_o,
  output mrs_pkg::out_t res_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int FW   = $clog2(FRAME_BYTES);
  localparam int LW   = $clog2(FRAME_BYTES + 1);
  localparam int RW   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int RMAX = (FRAME_BYTES < 64) ? FRAME_BYTES : 64;
  localparam logic [9:0]  FRAME_LIM = 10'(FRAME_BYTES);
  localparam logic [LW-1:0] LEN_MAX = LW'(FRAME_BYTES);
  localparam logic [16:0] REG_LIM  = 17'(REG_COUNT);
  localparam logic [16:0] COIL_LIM = 17'(REG_COUNT * 16);
  localparam logic [16:0] RMAX_W   = 17'(RMAX);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_CRD, S_CACC, S_SERVE, S_WHI, S_WLO, S_WWR,
    S_HEAD, S_RRD, S_RHI, S_RLO, S_KRD, S_KUSE, S_CRCL, S_CRCH
  } state_e;

  typedef enum logic [1:0] {K_EXC, K_COIL, K_HOLD, K_ECHO} kind_e;

  state_e       state_q;
  kind_e        kind_q;
  logic [7:0]   slave_q;
  logic [15:0]  timeout_q;
  logic [LW-1:0] len_q;
  logic [15:0]  idle_q;
  logic [7:0]   hdr_q [7];
  logic [9:0]   exp_q;
  logic [9:0]   idx_q;
  logic [15:0]  crc_q;
  logic [7:0]   code_q;
  logic [2:0]   hcnt_q;
  logic [10:0]  j_q;
  logic [2:0]   k_q;
  logic [7:0]   bits_q;
  logic [7:0]   hi_q;
  logic [15:0]  wd_q;
  logic         res_valid_q;
  mrs_pkg::out_t res_q;

  logic [7:0]   fs_mem [FRAME_BYTES];
  logic [7:0]   fs_rdata_q;
  logic         fs_we;
  logic [FW-1:0] fs_raddr;

  logic          rs_we, rs_busy;
  logic [RW-1:0] rs_addr;
  logic [15:0]   rs_wdata, rs_rdata;

  logic         acc, cfg_wr;
  logic [7:0]   fn, bc;
  logic [15:0]  a_w, q_w;
  logic [16:0]  aq_sum, lin_sum, q2;
  logic [13:0]  nbytes;
  logic [9:0]   exp_len;
  logic [11:0]  wptr;
  logic [7:0]   code_d;
  logic [15:0]  idle_inc;
  logic         emit_en, emit_last, emit_crc;
  logic [7:0]   emit_byte, head_byte, coil_byte;
  logic         coil_bit, head_done, coil_flush;

  assign busy   = (state_q != S_IDLE) || rs_busy;
  assign acc    = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  assign prdata = (paddr[2] == mrs_pkg::REG_TIMEOUT) ? {16'h0000, timeout_q}
                                                     : {24'h000000, slave_q};

  assign fn      = hdr_q[1];
  assign a_w     = {hdr_q[2], hdr_q[3]};
  assign q_w     = {hdr_q[4], hdr_q[5]};
  assign bc      = hdr_q[6];
  assign aq_sum  = {1'b0, a_w} + {1'b0, q_w};
  assign lin_sum = {1'b0, a_w} + 17'(j_q);
  assign q2      = {q_w, 1'b0};
  assign nbytes  = 14'((17'(q_w) + 17'd7) >> 3);
  assign exp_len = {2'b00, bc} + 10'd9;
  assign wptr    = 12'd7 + {j_q[10:0], 1'b0};
  assign idle_inc = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;
  assign coil_bit = rs_rdata[lin_sum[3:0]];
  assign coil_byte = bits_q | (8'(coil_bit) << k_q);
  assign coil_flush = (k_q == 3'd7) || (j_q + 11'd1 == q_w[10:0]);
  assign head_done = (kind_q == K_ECHO) ? (hcnt_q == 3'd5) : (hcnt_q == 3'd2);

  // Exception code for the frame being served.
  always_comb begin
    code_d = mrs_pkg::EXC_NONE;
    priority if (fn == mrs_pkg::FN_READ_COILS) begin
      if (q_w == 16'd0 || q_w > 16'd2000 || 17'(nbytes) + 17'd5 > RMAX_W) begin
        code_d = mrs_pkg::EXC_VALUE;
      end else if (aq_sum > COIL_LIM) begin
        code_d = mrs_pkg::EXC_ADDRESS;
      end
    end else if (fn == mrs_pkg::FN_READ_HOLD) begin
      if (q_w == 16'd0 || q_w > 16'd125 || q2 + 17'd5 > RMAX_W) begin
        code_d = mrs_pkg::EXC_VALUE;
      end else if (aq_sum > REG_LIM) begin
        code_d = mrs_pkg::EXC_ADDRESS;
      end
    end else if (fn == mrs_pkg::FN_WRITE_ONE) begin
      if (17'(a_w) >= REG_LIM) begin
        code_d = mrs_pkg::EXC_ADDRESS;
      end
    end else if (fn == mrs_pkg::FN_WRITE_MANY) begin
      if (q_w == 16'd0 || q_w > 16'd123 || 17'(bc) != q2) begin
        code_d = mrs_pkg::EXC_VALUE;
      end else if (aq_sum > REG_LIM) begin
        code_d = mrs_pkg::EXC_ADDRESS;
      end
    end else begin
      code_d = mrs_pkg::EXC_FUNCTION;
    end
  end

  // Header bytes of the reply.
  always_comb begin
    unique case (hcnt_q)
      3'd0: head_byte = hdr_q[0];
      3'd1: head_byte = (kind_q == K_EXC) ? (fn | mrs_pkg::FN_EXC_FLAG) : fn;
      3'd2: begin
        unique case (kind_q)
          K_EXC:  head_byte = code_q;
          K_COIL: head_byte = nbytes[7:0];
          K_HOLD: head_byte = q2[7:0];
          K_ECHO: head_byte = hdr_q[2];
          default: head_byte = hdr_q[2];
        endcase
      end
      3'd3: head_byte = hdr_q[3];
      3'd4: head_byte = hdr_q[4];
      3'd5: head_byte = hdr_q[5];
      default: head_byte = hdr_q[0];
    endcase
  end

  // Memory addressing and reply byte selection per state.
  always_comb begin
    fs_we     = acc && (item_i.op == mrs_pkg::OP_BYTE) && (len_q < LEN_MAX);
    fs_raddr  = idx_q[FW-1:0];
    rs_we     = 1'b0;
    rs_addr   = lin_sum[RW-1:0];
    rs_wdata  = {hi_q, fs_rdata_q};
    emit_en   = 1'b0;
    emit_last = 1'b0;
    emit_crc  = 1'b1;
    emit_byte = head_byte;
    unique case (state_q)
      S_WHI: fs_raddr = wptr[FW-1:0];
      S_WLO: fs_raddr = FW'(wptr + 12'd1);
      S_WWR: rs_we = 1'b1;
      S_SERVE: begin
        rs_addr  = a_w[RW-1:0];
        rs_wdata = q_w;
        rs_we    = (fn == mrs_pkg::FN_WRITE_ONE) && (code_d == mrs_pkg::EXC_NONE);
      end
      S_KRD: rs_addr = lin_sum[4 +: RW];
      S_HEAD: emit_en = 1'b1;
      S_RHI: begin
        emit_en   = 1'b1;
        emit_byte = rs_rdata[15:8];
      end
      S_RLO: begin
        emit_en   = 1'b1;
        emit_byte = wd_q[7:0];
      end
      S_KUSE: begin
        rs_addr   = lin_sum[4 +: RW];
        emit_en   = coil_flush;
        emit_byte = coil_byte;
      end
      S_CRCL: begin
        emit_en   = 1'b1;
        emit_crc  = 1'b0;
        emit_byte = crc_q[7:0];
      end
      S_CRCH: begin
        emit_en   = 1'b1;
        emit_crc  = 1'b0;
        emit_last = 1'b1;
        emit_byte = crc_q[15:8];
      end
      default: ;
    endcase
  end

  // Frame RAM: byte writes at the fill pointer, one registered read port.
  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      fs_mem[len_q[FW-1:0]] <= item_i.rx_byte;
    end
    fs_rdata_q <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q   <= 8'd1;
      timeout_q <= 16'd64;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        mrs_pkg::REG_SLAVE_ADDR: slave_q   <= pwdata[7:0];
        mrs_pkg::REG_TIMEOUT:    timeout_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (fs_we && len_q < LW'(7)) begin
      hdr_q[len_q[2:0]] <= item_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= K_EXC;
      len_q       <= '0;
      idle_q      <= '0;
      exp_q       <= '0;
      idx_q       <= '0;
      crc_q       <= mrs_pkg::CRC_INIT;
      code_q      <= mrs_pkg::EXC_NONE;
      hcnt_q      <= '0;
      j_q         <= '0;
      k_q         <= '0;
      bits_q      <= '0;
      hi_q        <= '0;
      wd_q        <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= emit_en;
      if (emit_en) begin
        res_q.tx_byte   <= emit_byte;
        res_q.last_byte <= emit_last;
        if (emit_crc) begin
          crc_q <= mrs_pkg::crc_byte(crc_q, emit_byte);
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (item_i.op == mrs_pkg::OP_TICK) begin
              // Count idle ticks only while a frame is partial.
              if (len_q != '0) begin
                if (idle_inc >= timeout_q) begin
                  len_q  <= '0;
                  idle_q <= '0;
                end else begin
                  idle_q <= idle_inc;
                end
              end else begin
                idle_q <= '0;
              end
            end else begin
              idle_q <= '0;
              if (len_q >= LEN_MAX) begin
                len_q <= '0;
              end else begin
                len_q   <= len_q + LW'(1);
                state_q <= S_DECIDE;
              end
            end
          end
        end
        S_DECIDE: begin
          state_q <= S_IDLE;
          if (len_q >= LW'(5)) begin
            priority if (hdr_q[0] != slave_q) begin
              len_q <= '0;
            end else if (fn >= mrs_pkg::FN_READ_COILS && fn <= mrs_pkg::FN_LAST_FIXED) begin
              if (len_q == LW'(8)) begin
                len_q   <= '0;
                exp_q   <= 10'd8;
                idx_q   <= '0;
                crc_q   <= mrs_pkg::CRC_INIT;
                state_q <= S_CRD;
              end
            end else if (fn == mrs_pkg::FN_WRITE_COILS || fn == mrs_pkg::FN_WRITE_MANY) begin
              if (len_q >= LW'(7)) begin
                if (exp_len > FRAME_LIM) begin
                  len_q <= '0;
                end else if (10'(len_q) == exp_len) begin
                  len_q   <= '0;
                  exp_q   <= exp_len;
                  idx_q   <= '0;
                  crc_q   <= mrs_pkg::CRC_INIT;
                  state_q <= S_CRD;
                end
              end
            end else begin
              len_q <= '0;
            end
          end
        end
        S_CRD: state_q <= S_CACC;
        S_CACC: begin
          // Residue over data plus appended CRC is zero for a good frame.
          if (idx_q + 10'd1 == exp_q) begin
            state_q <= (mrs_pkg::crc_byte(crc_q, fs_rdata_q) == 16'h0000) ? S_SERVE
                                                                          : S_IDLE;
          end else begin
            crc_q   <= mrs_pkg::crc_byte(crc_q, fs_rdata_q);
            idx_q   <= idx_q + 10'd1;
            state_q <= S_CRD;
          end
        end
        S_SERVE: begin
          crc_q  <= mrs_pkg::CRC_INIT;
          code_q <= code_d;
          hcnt_q <= '0;
          j_q    <= '0;
          k_q    <= '0;
          bits_q <= '0;
          state_q <= S_HEAD;
          if (code_d != mrs_pkg::EXC_NONE) begin
            kind_q <= K_EXC;
          end else if (fn == mrs_pkg::FN_READ_COILS) begin
            kind_q <= K_COIL;
          end else if (fn == mrs_pkg::FN_READ_HOLD) begin
            kind_q <= K_HOLD;
          end else begin
            kind_q <= K_ECHO;
            if (fn == mrs_pkg::FN_WRITE_MANY) begin
              state_q <= S_WHI;
            end
          end
        end
        S_WHI: state_q <= S_WLO;
        S_WLO: begin
          hi_q    <= fs_rdata_q;
          state_q <= S_WWR;
        end
        S_WWR: begin
          // Rewind the word index after the last write so the reply starts clean.
          j_q     <= (j_q + 11'd1 == q_w[10:0]) ? 11'd0 : j_q + 11'd1;
          state_q <= (j_q + 11'd1 == q_w[10:0]) ? S_HEAD : S_WHI;
        end
        S_HEAD: begin
          hcnt_q <= hcnt_q + 3'd1;
          if (head_done) begin
            unique case (kind_q)
              K_COIL:  state_q <= S_KRD;
              K_HOLD:  state_q <= S_RRD;
              default: state_q <= S_CRCL;
            endcase
          end
        end
        S_RRD: state_q <= S_RHI;
        S_RHI: begin
          wd_q    <= rs_rdata;
          state_q <= S_RLO;
        end
        S_RLO: begin
          j_q     <= j_q + 11'd1;
          state_q <= (j_q + 11'd1 == q_w[10:0]) ? S_CRCL : S_RRD;
        end
        S_KRD: state_q <= S_KUSE;
        S_KUSE: begin
          // Pack coils LSB first; flush on a full byte or the last coil.
          if (coil_flush) begin
            bits_q <= '0;
            k_q    <= '0;
          end else begin
            bits_q <= coil_byte;
            k_q    <= k_q + 3'd1;
          end
          j_q     <= j_q + 11'd1;
          state_q <= (j_q + 11'd1 == q_w[10:0]) ? S_CRCL : S_KRD;
        end
        S_CRCL: state_q <= S_CRCH;
        S_CRCH: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  mrs_reg_store #(
    .REG_COUNT(REG_COUNT),
    .RW       (RW)
  ) u_reg_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (rs_we),
    .addr_i (rs_addr),
    .wdata_i(rs_wdata),
    .rdata_o(rs_rdata),
    .busy_o (rs_busy)
  );

endmodule

>>> test/tb_modbus_rtu_slave_register_engine_top.sv
// Self-checking testbench for the Modbus RTU slave register engine.
`timescale 1ns / 1ps

module tb_modbus_rtu_slave_register_engine_top;

  localparam int FRAMES = 64;
  localparam int REGS   = 256;
  localparam int RANDOM_ITEMS = 210;

  // Shadow of the slave: own copy of the frame buffer, holding registers and
  // configuration, plus the reply bytes still owed by the block.
  class slave_mirror;
    logic [7:0]  frame_buf[FRAMES];
    int          frame_len;
    int          idle_ticks;
    logic [15:0] holding[REGS];
    logic [7:0]  own_addr;
    logic [15:0] tmo_ticks;
    mrs_pkg::out_t pending_reply[$];
    int          errors;

    function new();
      foreach (holding[i]) holding[i] = '0;
      foreach (frame_buf[i]) frame_buf[i] = '0;
      frame_len = 0; idle_ticks = 0; own_addr = 8'd1; tmo_ticks = 16'd64; errors = 0;
    endfunction

    function logic [15:0] word_at(int i);
      return {frame_buf[i], frame_buf[i+1]};
    endfunction

    static function logic [15:0] crc_fold(logic [15:0] c, logic [7:0] b);
      c ^= {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ mrs_pkg::CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void exc_reply(ref logic [7:0] rep[$], input logic [7:0] fn, input logic [7:0] code);
      rep = {};
      rep.push_back(own_addr);
      rep.push_back(fn | mrs_pkg::FN_EXC_FLAG);
      rep.push_back(code);
    endfunction

    // Serve a CRC-clean frame and queue the reply bytes it owes.
    function void serve_frame();
      logic [7:0]  rep[$];
      logic [7:0]  fn, bc, v;
      int          a, q, nb, c;
      logic [15:0] crc;
      fn = frame_buf[1]; a = word_at(2); q = word_at(4);
      if (fn == mrs_pkg::FN_READ_COILS) begin
        nb = (q + 7) / 8;
        if (q == 0 || q > 2000 || 5 + nb > 64) exc_reply(rep, fn, mrs_pkg::EXC_VALUE);
        else if (a + q > REGS * 16) exc_reply(rep, fn, mrs_pkg::EXC_ADDRESS);
        else begin
          rep = '{own_addr, fn, nb[7:0]};
          for (int i = 0; i < nb; i++) begin
            v = '0;
            for (int k = 0; k < 8 && i * 8 + k < q; k++) begin
              c = a + i * 8 + k;
              v[k] = holding[(c / 16) % REGS][c % 16];
            end
            rep.push_back(v);
          end
        end
      end else if (fn == mrs_pkg::FN_READ_HOLD) begin
        if (q == 0 || q > 125 || 5 + 2 * q > 64) exc_reply(rep, fn, mrs_pkg::EXC_VALUE);
        else if (a + q > REGS) exc_reply(rep, fn, mrs_pkg::EXC_ADDRESS);
        else begin
          rep = '{own_addr, fn, 8'(2 * q)};
          for (int i = 0; i < q; i++) begin
            rep.push_back(holding[(a + i) % REGS][15:8]);
            rep.push_back(holding[(a + i) % REGS][7:0]);
          end
        end
      end else if (fn == mrs_pkg::FN_WRITE_ONE) begin
        if (a >= REGS) exc_reply(rep, fn, mrs_pkg::EXC_ADDRESS);
        else begin
          holding[a] = q[15:0];
          for (int i = 0; i < 6; i++) rep.push_back(frame_buf[i]);
        end
      end else if (fn == mrs_pkg::FN_WRITE_MANY) begin
        bc = frame_buf[6];
        if (q == 0 || q > 123 || bc != 2 * q) exc_reply(rep, fn, mrs_pkg::EXC_VALUE);
        else if (a + q > REGS) exc_reply(rep, fn, mrs_pkg::EXC_ADDRESS);
        else begin
          for (int i = 0; i < q; i++) holding[(a + i) % REGS] = word_at(7 + 2 * i);
          for (int i = 0; i < 6; i++) rep.push_back(frame_buf[i]);
        end
      end else begin
        exc_reply(rep, fn, mrs_pkg::EXC_FUNCTION);
      end
      crc = mrs_pkg::CRC_INIT;
      foreach (rep[i]) begin
        crc = crc_fold(crc, rep[i]);
        pending_reply.push_back('{tx_byte: rep[i], last_byte: 1'b0});
      end
      pending_reply.push_back('{tx_byte: crc[7:0], last_byte: 1'b0});
      pending_reply.push_back('{tx_byte: crc[15:8], last_byte: 1'b1});
    endfunction

    // Advance the shadow by one accepted transfer.
    function void accept_item(mrs_pkg::in_t it);
      int          want;
      logic [15:0] crc;
      if (it.op == mrs_pkg::OP_TICK) begin
        if (frame_len > 0) begin
          if (idle_ticks < 16'hFFFF) idle_ticks++;
          if (idle_ticks >= tmo_ticks) begin
            frame_len = 0; idle_ticks = 0;
          end
        end else idle_ticks = 0;
        return;
      end
      idle_ticks = 0;
      if (frame_len >= FRAMES) begin
        frame_len = 0;
        return;
      end
      frame_buf[frame_len++] = it.rx_byte;
      if (frame_len < 5) return;
      if (frame_buf[0] != own_addr) begin
        frame_len = 0;
        return;
      end
      if (frame_buf[1] >= mrs_pkg::FN_READ_COILS && frame_buf[1] <= mrs_pkg::FN_LAST_FIXED)
        want = 8;
      else if (frame_buf[1] == mrs_pkg::FN_WRITE_COILS ||
               frame_buf[1] == mrs_pkg::FN_WRITE_MANY) begin
        if (frame_len < 7) return;
        want = frame_buf[6] + 9;
        if (want > FRAMES) begin
          frame_len = 0;
          return;
        end
      end else begin
        frame_len = 0;
        return;
      end
      if (frame_len != want) return;
      frame_len = 0;
      crc = mrs_pkg::CRC_INIT;
      for (int i = 0; i + 2 < want; i++) crc = crc_fold(crc, frame_buf[i]);
      if ({frame_buf[want-1], frame_buf[want-2]} != crc) return;
      serve_frame();
    endfunction

    function void check_reply_byte(mrs_pkg::out_t got);
      mrs_pkg::out_t want;
      if (pending_reply.size() == 0) begin
        $display("%0t: unexpected reply byte, expected none, actual %h/%b", $time,
                 got.tx_byte, got.last_byte);
        errors++;
        return;
      end
      want = pending_reply.pop_front();
      if (got.tx_byte !== want.tx_byte) begin
        $display("%0t: tx_byte mismatch, expected %h, actual %h", $time,
                 want.tx_byte, got.tx_byte);
        errors++;
      end
      if (got.last_byte !== want.last_byte) begin
        $display("%0t: last_byte mismatch, expected %b, actual %b", $time,
                 want.last_byte, got.last_byte);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni, start, busy;
  mrs_pkg::in_t  item_i;
  logic        res_valid_o;
  mrs_pkg::out_t res_o;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  slave_mirror mirror = new();
  int          idle_pct;
  int          bytes_sent, ticks_sent, frames_sent, reply_bytes;

  modbus_rtu_slave_register_engine_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .res_valid_o(res_valid_o), .res_o(res_o), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Results cannot be stalled: check every strobed byte on the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      mirror.check_reply_byte(res_o);
      reply_bytes++;
    end
  end

  // Hold start high with the item until the block takes it; a random gap
  // beforehand drops start so idle cycles land on every phase of the work.
  task automatic send_item(logic op, logic [7:0] b);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= '{op: op, rx_byte: b};
    do @(posedge clk_i); while (busy);
    mirror.accept_item('{op: op, rx_byte: b});
    if (op == mrs_pkg::OP_TICK) ticks_sent++;
    else bytes_sent++;
  endtask

  // Append the CRC (low byte first) unless asked to corrupt it, then transfer.
  task automatic send_frame(logic [7:0] body[$], bit bad_crc = 1'b0);
    logic [15:0] crc;
    crc = mrs_pkg::CRC_INIT;
    foreach (body[i]) crc = slave_mirror::crc_fold(crc, body[i]);
    if (bad_crc) crc ^= 16'(1 << $urandom_range(15));
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    foreach (body[i]) send_item(mrs_pkg::OP_BYTE, body[i]);
    frames_sent++;
  endtask

  function automatic void fill_header(ref logic [7:0] body[$], input logic [7:0] fn,
                                      input logic [15:0] a, input logic [15:0] q);
    body = '{mirror.own_addr, fn, a[15:8], a[7:0], q[15:8], q[7:0]};
  endfunction

  function automatic void fill_words(ref logic [7:0] body[$], input int bc, input int words);
    body.push_back(bc[7:0]);
    repeat (words) begin
      body.push_back(8'($urandom));
      body.push_back(8'($urandom));
    end
  endfunction

  // Let the block settle: owed replies out, busy low, then a further margin
  // of idle clocks with start held low.
  task automatic drain();
    start <= 1'b0;
    while (mirror.pending_reply.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy);
    repeat (800) @(posedge clk_i);
  endtask

  // APB write with a setup phase and an access phase; the register updates on the access edge.
  task automatic cfg_write(logic reg_sel, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= (reg_sel == mrs_pkg::REG_TIMEOUT) ? 3'd4 : 3'd0;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (reg_sel == mrs_pkg::REG_SLAVE_ADDR) mirror.own_addr = value[7:0];
    else mirror.tmo_ticks = value[15:0];
  endtask

  // One random request: mostly well-formed frames with random content, the
  // rest noise, stray ticks, broken CRCs and frames left to time out.
  task automatic random_request();
    logic [7:0]  body[$];
    logic [15:0] a, q;
    int          r, words;
    r = $urandom_range(99);
    if (r < 6) begin
      send_item(mrs_pkg::OP_BYTE, 8'($urandom));
      return;
    end
    if (r < 10) begin
      send_item(mrs_pkg::OP_TICK, 8'($urandom));
      return;
    end
    r = $urandom_range(99);
    if (r < 28) begin
      a = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(255));
      q = ($urandom_range(9) == 0) ? 16'($urandom_range(140)) : 16'($urandom_range(1, 12));
      fill_header(body, mrs_pkg::FN_READ_HOLD, a, q);
    end else if (r < 50) begin
      a = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(255));
      fill_header(body, mrs_pkg::FN_WRITE_ONE, a, 16'($urandom));
    end else if (r < 70) begin
      a = ($urandom_range(9) == 0) ? 16'($urandom_range(240, 300)) : 16'($urandom_range(255));
      q = 16'($urandom_range(1, 6));
      words = q;
      if ($urandom_range(9) == 0) q = 16'($urandom_range(0, 130));
      fill_header(body, mrs_pkg::FN_WRITE_MANY, a, q);
      fill_words(body, 2 * words, words);
    end else if (r < 88) begin
      a = 16'($urandom_range(4095));
      q = ($urandom_range(7) == 0) ? 16'($urandom_range(2100)) : 16'($urandom_range(1, 64));
      fill_header(body, mrs_pkg::FN_READ_COILS, a, q);
    end else begin
      r = $urandom_range(4);
      fill_header(body, (r == 0) ? mrs_pkg::FN_READ_DISCRETE :
                  (r == 1) ? mrs_pkg::FN_READ_INPUT : (r == 2) ? mrs_pkg::FN_WRITE_COIL :
                  (r == 3) ? mrs_pkg::FN_WRITE_COILS : 8'($urandom),
                  16'($urandom), 16'($urandom));
      if (body[1] == mrs_pkg::FN_WRITE_COILS || body[1] == mrs_pkg::FN_WRITE_MANY)
        fill_words(body, 2, 1);
    end
    if ($urandom_range(19) == 0) body[0] = 8'($urandom);
    // Occasionally stop mid-frame and tick it out when the timeout is short.
    if (mirror.tmo_ticks <= 16 && $urandom_range(9) == 0) begin
      for (int i = 0; i < 3; i++) send_item(mrs_pkg::OP_BYTE, body[i]);
      repeat (mirror.tmo_ticks + 1) send_item(mrs_pkg::OP_TICK, 8'h00);
      return;
    end
    if ($urandom_range(19) == 0) send_item(mrs_pkg::OP_TICK, 8'h00);
    send_frame(body, $urandom_range(9) == 0);
  endtask

  task automatic random_phase(int pct, int n_items);
    int target;
    idle_pct = pct;
    target = bytes_sent + ticks_sent + n_items;
    while (bytes_sent + ticks_sent < target) random_request();
    drain();
  endtask

  initial begin
    logic [7:0] body[$];
    rst_ni = 1'b0; start = 1'b0; item_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    idle_pct = 0; bytes_sent = 0; ticks_sent = 0; frames_sent = 0; reply_bytes = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes of each function and every exception path.
    fill_header(body, mrs_pkg::FN_WRITE_ONE, 16'd255, 16'hFFFF);   send_frame(body);
    fill_header(body, mrs_pkg::FN_WRITE_ONE, 16'd0, 16'hA5C3);     send_frame(body);
    fill_header(body, mrs_pkg::FN_WRITE_ONE, 16'd256, 16'h1234);   send_frame(body);
    fill_header(body, mrs_pkg::FN_READ_HOLD, 16'd0, 16'd1);        send_frame(body);
    fill_header(body, mrs_pkg::FN_READ_HOLD, 16'd227, 16'd29);     send_frame(body);
    fill_header(body, mrs_pkg::FN_READ_HOLD, 16'd0, 16'd30);       send_frame(body);
    fill_header(body, mrs_pkg::FN_READ_HOLD, 16'd0, 16'd0);        send_frame(body);
    fill_header(body, mrs_pkg::FN_READ_HOLD, 16'd0, 16'd126);      send_frame(body);
    fill_header(body, mrs_pkg::FN_READ_HOLD, 16'd250, 16'd10);     send_frame(body);
    fill_header(body, mrs_pkg::FN_READ_COILS, 16'd0, 16'd16);      send_frame(body);
    fill_header(body, mrs_pkg::FN_READ_COILS, 16'd4083, 16'd13);   send_frame(body);
    fill_header(body, mrs_pkg::FN_READ_COILS, 16'd0, 16'd0);       send_frame(body);
    fill_header(body, mrs_pkg::FN_READ_COILS, 16'd0, 16'd2001);    send_frame(body);
    fill_header(body, mrs_pkg::FN_READ_COILS, 16'd0, 16'd480);     send_frame(body);
    fill_header(body, mrs_pkg::FN_READ_COILS, 16'd4095, 16'd2);    send_frame(body);
    fill_header(body, mrs_pkg::FN_WRITE_MANY, 16'd254, 16'd2);
    fill_words(body, 4, 2); send_frame(body);
    fill_header(body, mrs_pkg::FN_WRITE_MANY, 16'd255, 16'd2);
    fill_words(body, 4, 2); send_frame(body);
    fill_header(body, mrs_pkg::FN_WRITE_MANY, 16'd0, 16'd0);
    fill_words(body, 0, 0); send_frame(body);
    fill_header(body, mrs_pkg::FN_WRITE_MANY, 16'd0, 16'd2);
    fill_words(body, 2, 1); send_frame(body);
    fill_header(body, mrs_pkg::FN_WRITE_MANY, 16'd0, 16'd28);
    fill_words(body, 56, 0);
    foreach (body[i]) send_item(mrs_pkg::OP_BYTE, body[i]);  // declared length too large
    fill_header(body, mrs_pkg::FN_WRITE_COILS, 16'd0, 16'd8);
    fill_words(body, 1, 0);
    body.push_back(8'hFF);                                           send_frame(body);
    fill_header(body, mrs_pkg::FN_READ_DISCRETE, 16'd0, 16'd1);      send_frame(body);
    fill_header(body, mrs_pkg::FN_READ_INPUT, 16'd0, 16'd1);         send_frame(body);
    fill_header(body, mrs_pkg::FN_WRITE_COIL, 16'd0, 16'hFF00);      send_frame(body);
    fill_header(body, mrs_pkg::FN_READ_STATUS, 16'd0, 16'd1);        send_frame(body);
    fill_header(body, mrs_pkg::FN_READ_HOLD, 16'd0, 16'd1); body[0] = 8'd9; send_frame(body);
    fill_header(body, mrs_pkg::FN_READ_HOLD, 16'd0, 16'd1);          send_frame(body, 1'b1);
    drain();

    // Idle timeout, including a zero setting that drops on the first tick.
    cfg_write(mrs_pkg::REG_TIMEOUT, 32'd3);
    fill_header(body, mrs_pkg::FN_READ_HOLD, 16'd0, 16'd2);
    for (int i = 0; i < 4; i++) send_item(mrs_pkg::OP_BYTE, body[i]);
    repeat (3) send_item(mrs_pkg::OP_TICK, 8'h00);
    send_frame(body);
    drain();
    cfg_write(mrs_pkg::REG_TIMEOUT, 32'd0);
    send_item(mrs_pkg::OP_BYTE, mirror.own_addr);
    send_item(mrs_pkg::OP_TICK, 8'h00);
    send_frame(body);
    drain();

    // Random phases across several settings, the extremes among them.
    cfg_write(mrs_pkg::REG_SLAVE_ADDR, 32'd247);
    cfg_write(mrs_pkg::REG_TIMEOUT, 32'd65535);
    random_phase(35, RANDOM_ITEMS / 3);
    cfg_write(mrs_pkg::REG_SLAVE_ADDR, 32'd1);
    cfg_write(mrs_pkg::REG_TIMEOUT, 32'd1);
    random_phase(71, RANDOM_ITEMS / 3);
    cfg_write(mrs_pkg::REG_SLAVE_ADDR, 32'h5A);
    cfg_write(mrs_pkg::REG_TIMEOUT, 32'd12);
    random_phase(0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    $display("Run covered %0d frames, %0d bytes and %0d ticks sent, %0d reply bytes checked.",
             frames_sent, bytes_sent, ticks_sent, reply_bytes);
    $display("Functions 1/3/6/16, exceptions 1-3, drops, bad CRC, timeouts, three settings.");
    if (mirror.errors == 0 && mirror.pending_reply.size() == 0) begin
      $display("tb_modbus_rtu_slave_register_engine_top OK");
    end else begin
      $display("tb_modbus_rtu_slave_register_engine_top NOT OK");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #20ms;
    $display("tb_modbus_rtu_slave_register_engine_top NOT OK");
    $finish;
  end

endmodule
